// File: rtl/joystick_axis_speed_direction_defines.svh
// assertion macros shared by the joystick speed block
`ifndef JOYSTICK_AXIS_SPEED_DIRECTION_DEFINES_SVH
`define JOYSTICK_AXIS_SPEED_DIRECTION_DEFINES_SVH

// same-cycle implication
`define JASD_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("jasd assertion failed");

// next-cycle implication
`define JASD_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("jasd assertion failed");

`endif

// File: rtl/jasd_pkg.sv
// types, codes and microprogram of the joystick speed block
`default_nettype none
package jasd_pkg;

    localparam int SPEED_BITS   = 7;
    localparam int OUT_W        = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int PC_BITS      = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_CENTER    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_CENTER    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_MIN_START = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_MAX_START = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_MIN_START = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_MAX_START = 3'd5;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_IN_BEAT  = 2'd1;
    localparam logic [1:0] COND_DIV_LAST = 2'd2;
    localparam logic [1:0] COND_OUT_FREE = 2'd3;

    localparam logic AXIS_Y = 1'b0;
    localparam logic AXIS_X = 1'b1;

    // program steps
    localparam logic [PC_BITS-1:0] STEP_WAIT    = 3'd0;
    localparam logic [PC_BITS-1:0] STEP_SETUP_Y = 3'd1;
    localparam logic [PC_BITS-1:0] STEP_DIV_Y   = 3'd2;
    localparam logic [PC_BITS-1:0] STEP_SWAP    = 3'd3;
    localparam logic [PC_BITS-1:0] STEP_DIV_X   = 3'd4;
    localparam logic [PC_BITS-1:0] STEP_STORE_X = 3'd5;
    localparam logic [PC_BITS-1:0] STEP_EMIT    = 3'd6;

    typedef struct packed {
        logic               accept;
        logic               setup;
        logic               setup_axis;
        logic               div;
        logic               store;
        logic               store_axis;
        logic               emit;
        logic [1:0]         cond;
        logic [PC_BITS-1:0] target;
    } jasd_ctl_t;

    typedef struct packed {
        logic in_beat;
        logic div_last;
        logic out_free;
    } jasd_stat_t;

    function automatic jasd_ctl_t prog_word(input logic [PC_BITS-1:0] pc);
        jasd_ctl_t w;
        w = '0;
        unique case (pc)
            STEP_WAIT: begin
                w.accept = 1'b1;
                w.cond   = COND_IN_BEAT;
                w.target = STEP_SETUP_Y;
            end
            STEP_SETUP_Y: begin
                w.setup      = 1'b1;
                w.setup_axis = AXIS_Y;
                w.cond       = COND_ALWAYS;
                w.target     = STEP_DIV_Y;
            end
            STEP_DIV_Y: begin
                w.div    = 1'b1;
                w.cond   = COND_DIV_LAST;
                w.target = STEP_SWAP;
            end
            STEP_SWAP: begin
                w.store      = 1'b1;
                w.store_axis = AXIS_Y;
                w.setup      = 1'b1;
                w.setup_axis = AXIS_X;
                w.cond       = COND_ALWAYS;
                w.target     = STEP_DIV_X;
            end
            STEP_DIV_X: begin
                w.div    = 1'b1;
                w.cond   = COND_DIV_LAST;
                w.target = STEP_STORE_X;
            end
            STEP_STORE_X: begin
                w.store      = 1'b1;
                w.store_axis = AXIS_X;
                w.cond       = COND_ALWAYS;
                w.target     = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_WAIT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/jasd_seq.sv
// step counter and program rom of the joystick speed block
`default_nettype none
module jasd_seq
    import jasd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire jasd_stat_t stat,
    output jasd_ctl_t       ctl
);

    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic               cond_met;

    assign ctl = prog_word(pc_reg);

    always_comb begin
        unique case (ctl.cond)
            COND_ALWAYS:   cond_met = 1'b1;
            COND_IN_BEAT:  cond_met = stat.in_beat;
            COND_DIV_LAST: cond_met = stat.div_last;
            COND_OUT_FREE: cond_met = stat.out_free;
            default:       cond_met = 1'b0;
        endcase
        pc_next = cond_met ? ctl.target : pc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/jasd_dp.sv
// datapath: calibration registers, running spans, shared divider, result register
`default_nettype none
module jasd_dp
    import jasd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int FULL_SCALE  = 100
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire jasd_ctl_t                    ctl,
    output jasd_stat_t                        stat,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [SAMPLE_BITS-1:0]       y_in,
    input  wire logic [SAMPLE_BITS-1:0]       x_in,
    input  wire logic                         cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]       cfg_data,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [OUT_W-1:0]                  m_tdata
);

    localparam int SB  = SAMPLE_BITS;
    localparam int QB  = $clog2(FULL_SCALE + 1);
    localparam int NB  = SB + QB;
    localparam int CW  = $clog2(QB);
    localparam int SPW = QB + 1;
    localparam logic [SB-1:0]  CENTER_RST = SB'(32'd512);
    localparam logic [SB-1:0]  MAX_RST    = SB'(32'd1023);
    localparam logic [QB-1:0]  HALF_Q     = QB'(FULL_SCALE / 2);
    localparam logic [SPW-1:0] FS_S       = SPW'(FULL_SCALE);
    localparam logic [CW-1:0]  CNT_TOP    = CW'(QB - 1);
    localparam logic [NB-1:0]  FS_N       = NB'(FULL_SCALE);

    logic [SB-1:0] ycen_reg, xcen_reg;
    logic [SB-1:0] ylo_reg, yhi_reg, xlo_reg, xhi_reg;
    logic [SB-1:0] ys_reg, xs_reg;
    logic          fwd_reg, right_reg, changed_reg;
    logic [NB-1:0] rem_reg, dvs_reg;
    logic [QB-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          zero_reg;
    logic [SPEED_BITS-1:0] yspd_reg, xspd_reg;
    logic          m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic          in_beat, out_free, out_load;
    logic          y_up, y_dn, x_up, x_dn;
    logic [SB-1:0] s_sel, lo_sel, hi_sel, diff, span;
    logic          zero_next;
    logic [NB-1:0] num;
    logic          ge;
    logic [QB-1:0] dev;
    logic [SPW-1:0] spd, spd_sat;
    logic [SPW+SPEED_BITS-1:0] spd_wide;
    logic [SPEED_BITS-1:0] spd_out;

    assign s_tready = ctl.accept;
    assign in_beat  = s_tvalid && ctl.accept;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ctl.emit && out_free;

    assign stat.in_beat  = in_beat;
    assign stat.div_last = (cnt_reg == '0);
    assign stat.out_free = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // max test wins over min test, as in the span update rule
    always_comb begin
        y_up = y_in > yhi_reg;
        y_dn = !y_up && (y_in < ylo_reg);
        x_up = x_in > xhi_reg;
        x_dn = !x_up && (x_in < xlo_reg);
    end

    always_comb begin
        s_sel     = (ctl.setup_axis == AXIS_X) ? xs_reg  : ys_reg;
        lo_sel    = (ctl.setup_axis == AXIS_X) ? xlo_reg : ylo_reg;
        hi_sel    = (ctl.setup_axis == AXIS_X) ? xhi_reg : yhi_reg;
        diff      = s_sel - lo_sel;
        span      = hi_sel - lo_sel;
        zero_next = (hi_sel <= lo_sel) || (s_sel < lo_sel);
        num       = NB'(diff) * FS_N;
        ge        = rem_reg >= dvs_reg;
    end

    // fold position around the midpoint
    always_comb begin
        dev      = (q_reg >= HALF_Q) ? (q_reg - HALF_Q) : (HALF_Q - q_reg);
        spd      = {dev, 1'b0};
        spd_sat  = zero_reg ? '0 : ((spd > FS_S) ? FS_S : spd);
        spd_wide = {{SPEED_BITS{1'b0}}, spd_sat};
        spd_out  = spd_wide[SPEED_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ycen_reg     <= CENTER_RST;
            xcen_reg     <= CENTER_RST;
            ylo_reg      <= '0;
            yhi_reg      <= MAX_RST;
            xlo_reg      <= '0;
            xhi_reg      <= MAX_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_Y_CENTER:    ycen_reg <= cfg_data;
                    CFG_X_CENTER:    xcen_reg <= cfg_data;
                    CFG_Y_MIN_START: ylo_reg  <= cfg_data;
                    CFG_Y_MAX_START: yhi_reg  <= cfg_data;
                    CFG_X_MIN_START: xlo_reg  <= cfg_data;
                    CFG_X_MAX_START: xhi_reg  <= cfg_data;
                    default: ;
                endcase
            end else if (in_beat) begin
                if (y_up) yhi_reg <= y_in;
                if (y_dn) ylo_reg <= y_in;
                if (x_up) xhi_reg <= x_in;
                if (x_dn) xlo_reg <= x_in;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            ys_reg      <= y_in;
            xs_reg      <= x_in;
            fwd_reg     <= y_in >= ycen_reg;
            right_reg   <= x_in >= xcen_reg;
            changed_reg <= y_up || y_dn || x_up || x_dn;
        end
        if (ctl.store) begin
            if (ctl.store_axis == AXIS_X) begin
                xspd_reg <= spd_out;
            end else begin
                yspd_reg <= spd_out;
            end
        end
        // one quotient bit a step, divisor walks down from the top bit
        if (ctl.setup) begin
            rem_reg  <= num;
            dvs_reg  <= NB'(span) << (QB - 1);
            cnt_reg  <= CNT_TOP;
            zero_reg <= zero_next;
        end else if (ctl.div) begin
            if (ge) rem_reg <= rem_reg - dvs_reg;
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= {q_reg[QB-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (out_load) begin
            m_tdata_reg <= {7'b0, changed_reg, right_reg, fwd_reg, xspd_reg, yspd_reg};
        end
    end

endmodule
`default_nettype wire

// File: rtl/joystick_axis_speed_direction.sv
// top level of the two-axis joystick speed and direction block
//
//  channel  dir  handshake                  payload
//  s_       in   s_tvalid / s_tready        s_tdata: y sample, x sample
//  m_       out  m_tvalid / m_tready        m_tdata: y speed, x speed, fwd, right, changed
//  cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// each sample runs through the setup, divide, store and emit steps before the next is taken; the
// shared restoring divider, one quotient bit per step, runs once per axis
// reset loads centers with 512 and spans with 0 .. 1023, truncated to the sample width
// the next beat is taken while a result still sits in the output register;
// the sequencer holds on its emit step only while that register is full and m_tready is low
`default_nettype none
`include "joystick_axis_speed_direction_defines.svh"
module joystick_axis_speed_direction
    import jasd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int FULL_SCALE  = 100
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // fwd_rev_position, left_right_position, zero pad
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // fwd_rev_speed[6:0], left_right_speed[13:7], go_forward, turn_right, span_changed, pad
    output logic [OUT_W-1:0]                       m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]           cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]            cfg_data
);

    jasd_ctl_t  ctl;
    jasd_stat_t stat;

    assign cfg_ready = 1'b1;

    jasd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    jasd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FULL_SCALE  (FULL_SCALE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .y_in      (s_tdata[SAMPLE_BITS-1:0]),
        .x_in      (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `JASD_ASSERT_NXT(a_beat_starts_y, aclk, aresetn, s_tvalid && s_tready, ctl.setup && (ctl.setup_axis == AXIS_Y))
    `JASD_ASSERT_NXT(a_div_then_store, aclk, aresetn, ctl.div && stat.div_last, ctl.store)
    `JASD_ASSERT_IMP(a_result_from_emit, aclk, aresetn, $rose(m_tvalid), $past(ctl.emit))
    `JASD_ASSERT_NXT(a_emit_holds, aclk, aresetn, ctl.emit && !stat.out_free, ctl.emit)

endmodule
`default_nettype wire

// File: dv/joystick_axis_speed_direction_tb.sv
// self-checking testbench for the joystick speed and direction block
`timescale 1ns / 100ps
module joystick_axis_speed_direction_tb;
    import jasd_pkg::*;

    localparam int SAMPLE_MAX  = 1023;
    localparam int FULL_SCALE  = 100;
    localparam int HALF_SCALE  = 50;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 95;
    localparam int NUM_PHASES  = 9;

    typedef struct packed {
        logic [SPEED_BITS-1:0] fwd_rev_speed;
        logic [SPEED_BITS-1:0] left_right_speed;
        logic                  go_forward;
        logic                  turn_right;
        logic                  span_changed;
    } stick_result_t;

    // tracks calibration, running spans and the results still owed by the block
    class speed_direction_tracker;
        logic [9:0] center [2];
        logic [9:0] low_seen [2];
        logic [9:0] high_seen [2];
        stick_result_t owed_results [$];
        int errors;

        function new();
            center[AXIS_Y]    = 10'd512;
            center[AXIS_X]    = 10'd512;
            low_seen[AXIS_Y]  = 10'd0;
            low_seen[AXIS_X]  = 10'd0;
            high_seen[AXIS_Y] = 10'd1023;
            high_seen[AXIS_X] = 10'd1023;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [9:0] val);
            case (idx)
                CFG_Y_CENTER:    center[AXIS_Y] = val;
                CFG_X_CENTER:    center[AXIS_X] = val;
                CFG_Y_MIN_START: low_seen[AXIS_Y] = val;
                CFG_Y_MAX_START: high_seen[AXIS_Y] = val;
                CFG_X_MIN_START: low_seen[AXIS_X] = val;
                CFG_X_MAX_START: high_seen[AXIS_X] = val;
                default: ;
            endcase
        endfunction

        function bit widen(logic a, logic [9:0] s);
            if (s > high_seen[a]) begin
                high_seen[a] = s;
                return 1'b1;
            end
            if (s < low_seen[a]) begin
                low_seen[a] = s;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [SPEED_BITS-1:0] deflection(logic [9:0] s, logic [9:0] lo,
                                                   logic [9:0] hi);
            int pos;
            int dev;
            if (hi <= lo || s < lo)
                return '0;
            pos = ((int'(s) - int'(lo)) * FULL_SCALE) / (int'(hi) - int'(lo));
            dev = (pos >= HALF_SCALE) ? pos - HALF_SCALE : HALF_SCALE - pos;
            if (2 * dev > FULL_SCALE)
                return SPEED_BITS'(FULL_SCALE);
            return SPEED_BITS'(2 * dev);
        endfunction

        function void note_sample(logic [9:0] ys, logic [9:0] xs);
            stick_result_t r;
            bit moved_y;
            bit moved_x;
            moved_y = widen(AXIS_Y, ys);
            moved_x = widen(AXIS_X, xs);
            r.fwd_rev_speed    = deflection(ys, low_seen[AXIS_Y], high_seen[AXIS_Y]);
            r.left_right_speed = deflection(xs, low_seen[AXIS_X], high_seen[AXIS_X]);
            r.go_forward       = (ys >= center[AXIS_Y]);
            r.turn_right       = (xs >= center[AXIS_X]);
            r.span_changed     = moved_y | moved_x;
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] beat);
            stick_result_t want;
            if (owed_results.size() == 0) begin
                $error("result beat %h arrived with nothing expected", beat);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (beat[6:0] !== want.fwd_rev_speed) begin
                $error("fwd_rev_speed: expected %0d, actual %0d", want.fwd_rev_speed, beat[6:0]);
                errors++;
            end
            if (beat[13:7] !== want.left_right_speed) begin
                $error("left_right_speed: expected %0d, actual %0d",
                       want.left_right_speed, beat[13:7]);
                errors++;
            end
            if (beat[14] !== want.go_forward) begin
                $error("go_forward: expected %0b, actual %0b", want.go_forward, beat[14]);
                errors++;
            end
            if (beat[15] !== want.turn_right) begin
                $error("turn_right: expected %0b, actual %0b", want.turn_right, beat[15]);
                errors++;
            end
            if (beat[16] !== want.span_changed) begin
                $error("span_changed: expected %0b, actual %0b", want.span_changed, beat[16]);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [23:0]             s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_W-1:0]        m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_Y_CENTER;
    logic [9:0]              cfg_data = '0;

    speed_direction_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    always #5 aclk = ~aclk;

    joystick_axis_speed_direction u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // receiver: random backpressure, plus long hold-offs on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("joystick_axis_speed_direction test failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [9:0] ys, input logic [9:0] xs);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, xs, ys};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_sample(ys, xs);
    endtask

    // stop offering and let every owed result come out
    task automatic drain;
        s_tvalid <= 1'b0;
        while (tracker.owed_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_calibration(input logic [9:0] yc, input logic [9:0] xc,
                                    input logic [9:0] ylo, input logic [9:0] yhi,
                                    input logic [9:0] xlo, input logic [9:0] xhi);
        logic [CFG_IDX_BITS-1:0] idx [6];
        logic [9:0] vals [6];
        idx  = '{CFG_Y_CENTER, CFG_X_CENTER, CFG_Y_MIN_START, CFG_Y_MAX_START,
                 CFG_X_MIN_START, CFG_X_MAX_START};
        vals = '{yc, xc, ylo, yhi, xlo, xhi};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            tracker.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] pick_bound();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 10'd0;
        if (r < 30)
            return 10'(SAMPLE_MAX);
        return 10'($urandom_range(SAMPLE_MAX, 0));
    endfunction

    // mostly inside the current span, with edges, centers and outliers mixed in
    function automatic logic [9:0] pick_sample(logic a);
        int lo;
        int hi;
        int c;
        int r;
        lo = tracker.low_seen[a];
        hi = tracker.high_seen[a];
        c  = tracker.center[a];
        r  = $urandom_range(0, 99);
        if (r < 55)
            return 10'($urandom_range(hi, lo));
        if (r < 72)
            return 10'($urandom_range(SAMPLE_MAX, 0));
        if (r < 82)
            return $urandom_range(0, 1) ? 10'(SAMPLE_MAX) : 10'd0;
        if (r < 91)
            return $urandom_range(0, 1) ? 10'(hi) : 10'(lo);
        c = c + $urandom_range(4, 0) - 2;
        if (c < 0)
            c = 0;
        if (c > SAMPLE_MAX)
            c = SAMPLE_MAX;
        return 10'(c);
    endfunction

    initial begin
        logic [9:0] ylo, yhi, xlo, xhi, t;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 35;
        recv_idle_pct = 47;

        // reset calibration: full span, centered at 512
        send_sample(10'd0, 10'd0);
        send_sample(10'd1023, 10'd1023);
        send_sample(10'd512, 10'd511);
        send_sample(10'd511, 10'd512);
        send_sample(10'd0, 10'd1023);
        send_sample(10'd1023, 10'd0);
        drain();

        // narrow span: full deflection at both ends, then widening both ways
        load_calibration(10'd500, 10'd200, 10'd300, 10'd700, 10'd200, 10'd800);
        send_sample(10'd700, 10'd800);
        send_sample(10'd300, 10'd200);
        send_sample(10'd500, 10'd500);
        send_sample(10'd800, 10'd100);
        send_sample(10'd100, 10'd900);
        drain();

        // inverted span on y, empty span on x
        load_calibration(10'd0, 10'd1023, 10'd600, 10'd400, 10'd512, 10'd512);
        send_sample(10'd500, 10'd512);
        send_sample(10'd400, 10'd600);
        send_sample(10'd700, 10'd0);
        send_sample(10'd1023, 10'd1023);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 47;
            end else if (p < 6) begin
                send_idle_pct = 47;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            ylo = pick_bound();
            yhi = pick_bound();
            xlo = pick_bound();
            xhi = pick_bound();
            // keep most spans ordered, leave some inverted
            if ($urandom_range(0, 99) < 85 && ylo > yhi) begin
                t = ylo;
                ylo = yhi;
                yhi = t;
            end
            if ($urandom_range(0, 99) < 85 && xlo > xhi) begin
                t = xlo;
                xlo = xhi;
                xhi = t;
            end
            load_calibration(pick_bound(), pick_bound(), ylo, yhi, xlo, xhi);
            if (p == 1 || p == 7)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(AXIS_Y), pick_sample(AXIS_X));
            drain();
        end

        repeat (25) @(posedge aclk);
        if (tracker.errors == 0 && tracker.owed_results.size() == 0)
            $display("joystick_axis_speed_direction test passed");
        else
            $display("joystick_axis_speed_direction test failed");
        $finish;
    end

endmodule

// File: joystick_axis_speed_direction.f
+incdir+rtl
rtl/jasd_pkg.sv
rtl/jasd_seq.sv
rtl/jasd_dp.sv
rtl/joystick_axis_speed_direction.sv
dv/joystick_axis_speed_direction_tb.sv
